// ===== rtl/core/rfkf_pkg.sv =====
package rfkf_pkg;

   localparam int STEP_W = 4;
   localparam int CSR_IDX_W = 3;

   typedef logic [STEP_W-1:0] step_type;

   // Frame parser positions
   localparam logic [1:0] POS_HUNT  = 2'd0;
   localparam logic [1:0] POS_HIGH  = 2'd1;
   localparam logic [1:0] POS_LOW   = 2'd2;
   localparam logic [1:0] POS_CHECK = 2'd3;

   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CHECKSUM = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROCESS_NOISE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEASURE_NOISE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISTANCE  = 3'd3;

   localparam logic [15:0] RST_PROCESS_NOISE = 16'd64;
   localparam logic [15:0] RST_MEASURE_NOISE = 16'd1600;
   localparam logic [15:0] RST_MIN_DISTANCE  = 16'd250;
   localparam logic [15:0] RST_MAX_DISTANCE  = 16'd7500;
   localparam logic [31:0] RST_VARIANCE      = 32'd16000;

   typedef enum logic [3:0] {
      OP_NOP      = 4'd0,
      OP_EMIT     = 4'd1,
      OP_ADD_Q    = 4'd2,
      OP_DEN      = 4'd3,
      OP_DIV_INIT = 4'd4,
      OP_DIV_STEP = 4'd5,
      OP_K_ZERO   = 4'd6,
      OP_MUL_X    = 4'd7,
      OP_UPD_X    = 4'd8,
      OP_MUL_P    = 4'd9,
      OP_UPD_P    = 4'd10,
      OP_PRIME    = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      C_NONE       = 3'd0,
      C_ALWAYS     = 3'd1,
      C_NO_START   = 3'd2,
      C_REJECT     = 3'd3,
      C_NOT_PRIMED = 3'd4,
      C_DEN_ZERO   = 3'd5,
      C_DIV_MORE   = 3'd6,
      C_OUT_BUSY   = 3'd7
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Program addresses
   localparam step_type S_EMIT     = 4'd0;
   localparam step_type S_IDLE     = 4'd1;
   localparam step_type S_CHECK    = 4'd2;
   localparam step_type S_PRIMED   = 4'd3;
   localparam step_type S_ADD_Q    = 4'd4;
   localparam step_type S_DEN      = 4'd5;
   localparam step_type S_DIV_INIT = 4'd6;
   localparam step_type S_DIV_STEP = 4'd7;
   localparam step_type S_MUL_X    = 4'd8;
   localparam step_type S_UPD_X    = 4'd9;
   localparam step_type S_MUL_P    = 4'd10;
   localparam step_type S_UPD_P    = 4'd11;
   localparam step_type S_K_ZERO   = 4'd12;
   localparam step_type S_PRIME    = 4'd13;

   // Control store: a jump is taken when the condition holds, else step + 1.
   function automatic ctrl_word_type rfkf_rom(input step_type step);
      ctrl_word_type cw;
      case (step)
         S_EMIT:     cw = '{OP_EMIT,     C_OUT_BUSY,   S_EMIT};
         S_IDLE:     cw = '{OP_NOP,      C_NO_START,   S_IDLE};
         S_CHECK:    cw = '{OP_NOP,      C_REJECT,     S_EMIT};
         S_PRIMED:   cw = '{OP_NOP,      C_NOT_PRIMED, S_PRIME};
         S_ADD_Q:    cw = '{OP_ADD_Q,    C_NONE,       S_IDLE};
         S_DEN:      cw = '{OP_DEN,      C_NONE,       S_IDLE};
         S_DIV_INIT: cw = '{OP_DIV_INIT, C_DEN_ZERO,   S_K_ZERO};
         S_DIV_STEP: cw = '{OP_DIV_STEP, C_DIV_MORE,   S_DIV_STEP};
         S_MUL_X:    cw = '{OP_MUL_X,    C_NONE,       S_IDLE};
         S_UPD_X:    cw = '{OP_UPD_X,    C_NONE,       S_IDLE};
         S_MUL_P:    cw = '{OP_MUL_P,    C_NONE,       S_IDLE};
         S_UPD_P:    cw = '{OP_UPD_P,    C_ALWAYS,     S_EMIT};
         S_K_ZERO:   cw = '{OP_K_ZERO,   C_ALWAYS,     S_MUL_X};
         S_PRIME:    cw = '{OP_PRIME,    C_ALWAYS,     S_EMIT};
         default:    cw = '{OP_NOP,      C_ALWAYS,     S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/core/range_frame_kalman_filter_core.sv =====
// Range sensor frame parser with a scalar Kalman filter.
//
// req_*: one sensor byte per transfer. Frames are 0xFF, distance high,
// distance low, checksum (low byte of the sum of the first three).
// rsp_*: one result per completed frame: status (ok, checksum error, out of
// range), the frame's raw distance in mm and the filtered distance in 1/16 mm.
// csr_*: writes to Q, R, min and max distance; csr_ready is always high.
//
// Header and distance bytes are taken without a stall. After the checksum
// byte req_stall is high while the microcoded sequencer runs: a rejected
// frame goes straight to output, the first good sample primes the filter,
// and a filter update runs the one-bit-per-cycle gain divider followed by
// two passes through the shared multiplier.
// The result sits in an output register; if rsp_stall holds it, the next
// result waits in the sequencer and bytes are not taken meanwhile.
// Reset (synchronous) clears the parser, sets the estimate to zero, the
// variance to 16000 and restores the register defaults.
module range_frame_kalman_filter_core
   import rfkf_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_frame_status,
   output logic [15:0]          rsp_raw_distance,
   output logic [19:0]          rsp_filtered_distance,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam int G      = GAIN_FRAC_BITS;
   localparam int KW     = G + 1;
   localparam int PROD_W = KW + 32;
   localparam int CNT_W  = $clog2(G + 1);

   localparam logic [KW-1:0]     ONE      = {1'b1, {G{1'b0}}};
   localparam logic [PROD_W-1:0] HALF     = PROD_W'(1) << (G - 1);
   localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(G);

   // configuration
   logic [15:0] q_ff, q_in;
   logic [15:0] r_ff, r_in;
   logic [15:0] min_ff, min_in;
   logic [15:0] max_ff, max_in;

   // parser
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  high_ff, high_in;
   logic [7:0]  low_ff, low_in;
   logic [1:0]  status_ff, status_in;

   // filter state
   logic [23:0] estimate_ff, estimate_in;
   logic [31:0] variance_ff, variance_in;
   logic        primed_ff, primed_in;

   // datapath
   logic [31:0]       p_ff, p_in;
   logic [32:0]       den_ff, den_in;
   logic [33:0]       rem_ff, rem_in;
   logic [KW-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [23:0]       diff_ff, diff_in;
   logic              dir_ff, dir_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   // sequencer and output
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          jump;
   logic          start;
   logic          in_fire;
   logic          out_busy;
   logic          out_load;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_dist_ff, rsp_dist_in;
   logic [19:0] rsp_filt_ff, rsp_filt_in;

   // combinational helpers
   logic [15:0]       frame_dist;
   logic [23:0]       z;
   logic [7:0]        sum;
   logic [32:0]       var_sum;
   logic              rem_ge;
   logic [33:0]       rem_sub;
   logic [KW-1:0]     mul_a;
   logic [31:0]       mul_b;
   logic [PROD_W-1:0] mul_full;
   logic [PROD_W-1:0] rnd;

   assign req_stall = (step_ff != S_IDLE);
   assign in_fire   = req_valid && !req_stall;
   assign start     = in_fire && (pos_ff == POS_CHECK);
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   assign cw         = rfkf_rom(step_ff);
   assign out_load   = (cw.op == OP_EMIT) && !out_busy;
   assign frame_dist = {high_ff, low_ff};
   assign z          = {frame_dist, 8'd0};
   assign sum        = HEADER_BYTE + high_ff + low_ff;
   assign var_sum    = {1'b0, variance_ff} + {17'd0, q_ff};
   assign rem_ge     = (rem_ff >= {1'b0, den_ff});
   assign rem_sub    = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   assign mul_a      = (cw.op == OP_MUL_P) ? (ONE - quot_ff) : quot_ff;
   assign mul_b      = (cw.op == OP_MUL_P) ? p_ff : {8'd0, diff_ff};
   assign mul_full   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign rnd        = prod_ff + HALF;

   always_comb begin
      case (cw.cond)
         C_NONE:       jump = 1'b0;
         C_ALWAYS:     jump = 1'b1;
         C_NO_START:   jump = !start;
         C_REJECT:     jump = (status_ff != ST_OK);
         C_NOT_PRIMED: jump = !primed_ff;
         C_DEN_ZERO:   jump = (den_ff == 33'd0);
         C_DIV_MORE:   jump = (cnt_ff != DIV_LAST);
         C_OUT_BUSY:   jump = out_busy;
         default:      jump = 1'b0;
      endcase
      step_in = jump ? cw.target : step_ff + step_type'(1);
   end

   // configuration writes
   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PROCESS_NOISE: q_in   = csr_wdata;
            REG_MEASURE_NOISE: r_in   = csr_wdata;
            REG_MIN_DISTANCE:  min_in = csr_wdata;
            REG_MAX_DISTANCE:  max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // byte parser
   always_comb begin
      pos_in    = pos_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      status_in = status_ff;
      if (in_fire) begin
         case (pos_ff)
            POS_HUNT: begin
               if (req_rx_byte == HEADER_BYTE) pos_in = POS_HIGH;
            end
            POS_HIGH: begin
               high_in = req_rx_byte;
               pos_in  = POS_LOW;
            end
            POS_LOW: begin
               low_in = req_rx_byte;
               pos_in = POS_CHECK;
            end
            default: begin
               // checksum byte is never reused as a header
               pos_in = POS_HUNT;
               if (sum != req_rx_byte) begin
                  status_in = ST_CHECKSUM;
               end else if (frame_dist < min_ff || frame_dist > max_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  status_in = ST_OK;
               end
            end
         endcase
      end
   end

   // datapath driven by the control word
   always_comb begin
      estimate_in = estimate_ff;
      variance_in = variance_ff;
      primed_in   = primed_ff;
      p_in        = p_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      cnt_in      = cnt_ff;
      diff_in     = diff_ff;
      dir_in      = dir_ff;
      prod_in     = prod_ff;
      case (cw.op)
         OP_PRIME: begin
            estimate_in = z;
            variance_in = {16'd0, r_ff};
            primed_in   = 1'b1;
         end
         OP_ADD_Q: begin
            p_in = var_sum[32] ? 32'hFFFF_FFFF : var_sum[31:0];
         end
         OP_DEN: begin
            den_in  = {1'b0, p_ff} + {17'd0, r_ff};
            dir_in  = (z >= estimate_ff);
            diff_in = (z >= estimate_ff) ? (z - estimate_ff) : (estimate_ff - z);
         end
         OP_DIV_INIT: begin
            rem_in  = {2'b00, p_ff};
            quot_in = '0;
            cnt_in  = '0;
         end
         OP_DIV_STEP: begin
            // restoring division, one quotient bit per cycle, MSB first
            rem_in  = {rem_sub[32:0], 1'b0};
            quot_in = {quot_ff[KW-2:0], rem_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         OP_K_ZERO: begin
            quot_in = '0;
         end
         OP_MUL_X, OP_MUL_P: begin
            prod_in = mul_full;
         end
         OP_UPD_X: begin
            estimate_in = dir_ff ? (estimate_ff + rnd[G +: 24])
                                 : (estimate_ff - rnd[G +: 24]);
         end
         OP_UPD_P: begin
            variance_in = rnd[G +: 32];
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_filt_in   = rsp_filt_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_dist_in   = frame_dist;
         rsp_filt_in   = estimate_ff[23:4];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= RST_PROCESS_NOISE;
         r_ff         <= RST_MEASURE_NOISE;
         min_ff       <= RST_MIN_DISTANCE;
         max_ff       <= RST_MAX_DISTANCE;
         pos_ff       <= POS_HUNT;
         estimate_ff  <= '0;
         variance_ff  <= RST_VARIANCE;
         primed_ff    <= 1'b0;
         step_ff      <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         r_ff         <= r_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pos_ff       <= pos_in;
         estimate_ff  <= estimate_in;
         variance_ff  <= variance_in;
         primed_ff    <= primed_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff       <= high_in;
      low_ff        <= low_in;
      status_ff     <= status_in;
      p_ff          <= p_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      cnt_ff        <= cnt_in;
      diff_ff       <= diff_in;
      dir_ff        <= dir_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_filt_ff   <= rsp_filt_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_status      = rsp_status_ff;
   assign rsp_raw_distance      = rsp_dist_ff;
   assign rsp_filtered_distance = rsp_filt_ff;

`ifndef ASSERT_OFF
   a_frame_starts_program: assert property (@(posedge clock) disable iff (reset)
      start |=> step_ff == S_CHECK)
      else $error("checksum byte did not start the sequencer");

   a_gain_in_range: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_MUL_X |-> quot_ff <= ONE)
      else $error("gain above one");

   a_reject_keeps_estimate: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_CHECK && status_ff != ST_OK |=> $stable(estimate_ff))
      else $error("rejected frame changed the estimate");

   a_variance_shrinks: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_UPD_P |=> variance_ff <= $past(p_ff))
      else $error("updated variance exceeds predicted variance");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench
   import rfkf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GAIN_BITS     = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int FRAME_BYTES   = 217;
   localparam int NUM_PHASES    = 7;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] raw;
      logic [19:0] filtered;
   } range_result_type;

   // Frame parser and Kalman filter predictor plus the queue of expected results.
   class range_scoreboard;
      logic [15:0] q_noise, r_noise, min_mm, max_mm;
      logic [1:0]  pos;
      logic [7:0]  hi_byte, lo_byte;
      logic [23:0] est;
      logic [31:0] variance;
      bit          primed;
      range_result_type pending_results[$];
      int          errors;

      function new();
         q_noise  = RST_PROCESS_NOISE;
         r_noise  = RST_MEASURE_NOISE;
         min_mm   = RST_MIN_DISTANCE;
         max_mm   = RST_MAX_DISTANCE;
         pos      = POS_HUNT;
         hi_byte  = '0;
         lo_byte  = '0;
         est      = '0;
         variance = RST_VARIANCE;
         primed   = 0;
         errors   = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
         case (idx)
            REG_PROCESS_NOISE: q_noise = v;
            REG_MEASURE_NOISE: r_noise = v;
            REG_MIN_DISTANCE:  min_mm = v;
            REG_MAX_DISTANCE:  max_mm = v;
            default: ;
         endcase
      endfunction

      function void kalman_update(logic [15:0] dist_mm);
         longint unsigned z, p, den, k, diff, mag, one, half;
         one  = 64'd1 << GAIN_BITS;
         half = one >> 1;
         z    = 64'({dist_mm, 8'h00});
         if (!primed) begin
            est      = z[23:0];
            variance = {16'd0, r_noise};
            primed   = 1;
            return;
         end
         p = 64'(variance) + 64'(q_noise);
         if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
         den = p + 64'(r_noise);
         k = (den == 0) ? 0 : (p << GAIN_BITS) / den;
         if (z >= est) begin
            diff = z - est;
            mag  = (k * diff + half) >> GAIN_BITS;
            est  = 24'(est + mag);
         end else begin
            diff = est - z;
            mag  = (k * diff + half) >> GAIN_BITS;
            est  = 24'(est - mag);
         end
         variance = 32'(((one - k) * p + half) >> GAIN_BITS);
      endfunction

      function void note_byte(logic [7:0] b);
         range_result_type res;
         logic [15:0]   dist_mm;
         logic [7:0]    sum;
         case (pos)
            POS_HUNT: if (b == HEADER_BYTE) pos = POS_HIGH;
            POS_HIGH: begin
               hi_byte = b;
               pos = POS_LOW;
            end
            POS_LOW: begin
               lo_byte = b;
               pos = POS_CHECK;
            end
            default: begin
               pos     = POS_HUNT;
               dist_mm = {hi_byte, lo_byte};
               sum     = HEADER_BYTE + hi_byte + lo_byte;
               if (sum != b) begin
                  res.status = ST_CHECKSUM;
               end else if (dist_mm < min_mm || dist_mm > max_mm) begin
                  res.status = ST_RANGE;
               end else begin
                  res.status = ST_OK;
                  kalman_update(dist_mm);
               end
               res.raw      = dist_mm;
               res.filtered = est[23:4];
               pending_results.push_back(res);
            end
         endcase
      endfunction

      function void check_result(logic [1:0] st, logic [15:0] raw, logic [19:0] filt);
         range_result_type exp_res;
         if (pending_results.size() == 0) begin
            $error("result with none expected: status %0d raw %0d filtered %0d",
                   st, raw, filt);
            errors++;
            return;
         end
         exp_res = pending_results.pop_front();
         if (st !== exp_res.status) begin
            $error("frame_status: expected %0d, got %0d", exp_res.status, st);
            errors++;
         end
         if (raw !== exp_res.raw) begin
            $error("raw_distance: expected %0d, got %0d", exp_res.raw, raw);
            errors++;
         end
         if (filt !== exp_res.filtered) begin
            $error("filtered_distance: expected %0d, got %0d", exp_res.filtered, filt);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_rx_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_frame_status;
   logic [15:0]          rsp_raw_distance;
   logic [19:0]          rsp_filtered_distance;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   range_scoreboard sb = new();
   bit  quiet;
   int  cycles;
   int  stall_run;

   range_frame_kalman_filter_core #(.GAIN_FRAC_BITS(GAIN_BITS)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_frame_status      (rsp_frame_status),
      .rsp_raw_distance      (rsp_raw_distance),
      .rsp_filtered_distance (rsp_filtered_distance),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 60) return 0;
      if (r < 95) return $urandom_range(4, 1);
      return $urandom_range(60, 10);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(2) == 0);
         stall_run <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_frame_status, rsp_raw_distance, rsp_filtered_distance);
   end

   task automatic send_byte(input logic [7:0] b);
      int g;
      g = pick_gap();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
   endtask

   task automatic send_frame(input logic [15:0] dist_mm, input bit corrupt);
      logic [7:0] ck;
      ck = HEADER_BYTE + dist_mm[15:8] + dist_mm[7:0];
      if (corrupt) ck = ck ^ 8'($urandom_range(255, 1));
      send_byte(HEADER_BYTE);
      send_byte(dist_mm[15:8]);
      send_byte(dist_mm[7:0]);
      send_byte(ck);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic program_regs(input logic [15:0] q, r, mn, mx);
      write_reg(REG_PROCESS_NOISE, q);
      write_reg(REG_MEASURE_NOISE, r);
      write_reg(REG_MIN_DISTANCE, mn);
      write_reg(REG_MAX_DISTANCE, mx);
      csr_valid <= 1'b0;
   endtask

   // wait for every expected result, then let a filter update finish
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_distance(input logic [15:0] lo, hi);
      int r;
      r = $urandom_range(99);
      if (r < 65 && lo <= hi) return 16'($urandom_range(hi, lo));
      if (r < 80) begin
         case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return lo - 16'd1;
            default: return hi + 16'd1;
         endcase
      end
      return 16'($urandom_range(16'hFFFF));
   endfunction

   task automatic random_traffic(input int n_bytes);
      int sent;
      int r;
      int n;
      sent = 0;
      while (sent < n_bytes) begin
         r = $urandom_range(99);
         if (r < 6) begin
            send_byte(8'($urandom_range(255)));
            sent += 1;
         end else if (r < 12) begin
            // truncated frame; the bytes that follow get parsed as its tail
            n = $urandom_range(2, 1);
            send_byte(HEADER_BYTE);
            repeat (n) send_byte(8'($urandom_range(255)));
            sent += n + 1;
         end else begin
            send_frame(pick_distance(sb.min_mm, sb.max_mm), $urandom_range(9) == 0);
            sent += 4;
         end
      end
   endtask

   initial begin
      logic [15:0] q, r, mn, mx;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      quiet       <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset register values, priming, range edges, bad checksum
      send_byte(8'h00);
      send_byte(8'h7E);
      send_frame(16'd1000, 0);
      send_frame(16'd7500, 0);
      send_frame(16'd250, 0);
      send_frame(16'd249, 0);
      send_frame(16'hFFFF, 0);
      // checksum byte of 0xFF must not start a new frame
      send_byte(HEADER_BYTE);
      send_byte(8'h03);
      send_byte(8'hE8);
      send_byte(HEADER_BYTE);
      send_byte(8'h55);
      send_frame(16'd0, 0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin q = 16'd64;    r = 16'd1600;  mn = 16'd250;   mx = 16'd7500;  end
            1: begin q = 16'd0;     r = 16'd0;     mn = 16'd0;     mx = 16'hFFFF;  end
            2: begin q = 16'hFFFF;  r = 16'hFFFF;  mn = 16'd0;     mx = 16'hFFFF;  end
            3: begin q = 16'd16;    r = 16'd1;     mn = 16'd1000;  mx = 16'd1200;  end
            4: begin q = 16'd100;   r = 16'd400;   mn = 16'd40000; mx = 16'd39999; end
            5: begin
               q  = 16'($urandom_range(16'hFFFF));
               r  = 16'($urandom_range(16'hFFFF));
               mn = 16'hFFFF;
               mx = 16'hFFFF;
            end
            default: begin
               q  = 16'($urandom_range(16'hFFFF));
               r  = 16'($urandom_range(16'hFFFF));
               mn = 16'($urandom_range(16'hFFFF));
               mx = 16'($urandom_range(16'hFFFF, mn));
            end
         endcase
         drain();
         quiet <= (ph == 1 || ph == 4);
         // index past the last register: the write must be dropped
         if (ph == 2)
            write_reg(CSR_IDX_W'(REG_MAX_DISTANCE + 1 + $urandom_range(3)),
                      16'($urandom_range(16'hFFFF)));
         program_regs(q, r, mn, mx);
         random_traffic(FRAME_BYTES);
      end

      drain();
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rfkf_pkg.sv
rtl/core/range_frame_kalman_filter_core.sv
sim/testbench.sv
